// ===== hw/rtl/msl_pkg.sv =====
// Package: shared types and constants for the monotone spline slope limiter.
package msl_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_PUT1 = 4'b0100,
		ST_PUT2 = 4'b1000
	} msl_state_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/msl_if.sv =====
// Interfaces: knot request channel and limited-slope result channel.
interface msl_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] knot_x;
	logic signed [VALUE_WIDTH-1:0] knot_y;
	logic signed [VALUE_WIDTH-1:0] knot_slope;
	logic                          last_knot;

	modport source (output valid, knot_x, knot_y, knot_slope, last_knot, input ready);
	modport sink (input valid, knot_x, knot_y, knot_slope, last_knot, output ready);
endinterface

interface msl_out_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] slope_out;
	logic                          was_clamped;
	logic                          order_error;
	logic                          last_out;

	modport source (output valid, slope_out, was_clamped, order_error, last_out, input ready);
	modport sink (input valid, slope_out, was_clamped, order_error, last_out, output ready);
endinterface

// ===== hw/rtl/msl_divider.sv =====
// Radix-2 restoring divider: quotient of (dividend << FRACTION_BITS) / divisor, saturated.
module msl_divider #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic [VALUE_WIDTH-1:0] quot,
	output msl_pkg::div_stat_t     stat
);

	localparam int NW = VALUE_WIDTH + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [NW-1:0]          num_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic                   sat_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [VALUE_WIDTH:0]   rem_sh;
	logic                   ge;
	logic [VALUE_WIDTH:0]   rem_sub;
	logic [VALUE_WIDTH-1:0] quot_sh;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign quot_sh = {quot_q[VALUE_WIDTH-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= {dividend, {FRACTION_BITS{1'b0}}};
			dvs_q  <= divisor;
			quot_q <= '0;
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
			num_q <= num_q << 1;
			if (!sat_q) begin
				if (quot_sh >= SIGN_BIT) begin
					quot_q <= SIGN_BIT;
					sat_q  <= 1'b1;
				end else begin
					quot_q <= quot_sh;
				end
			end
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/monotone_spline_slope_limiter.sv =====
// Top level: Hyman-style monotone slope limiter for cubic Hermite spline knots.
//
// Channels: knot_in takes one knot (x, y, slope, last_knot) per request, in
// order of increasing x. res_out gives the limited slope of a knot with
// was_clamped, order_error and last_out flags.
// Results lag by one knot: the result of a knot leaves once its right
// neighbour has arrived. A knot flagged last_knot flushes two results (its
// left neighbour, then itself); a lone last knot gives one.
// Sequencing: the first knot of a spline runs no division. Every later knot
// runs one secant division on the shared radix-2 divider, one quotient bit a
// cycle, then passes through the put states. knot_in.ready is high only
// while the sequencer is idle, so a new knot is not taken until the last one
// is through. An out-of-order x skips the division.
// Reset (arst_n low) drops any held knot and any pending result; the next
// knot starts a new spline.
// A stalled receiver: one result waits in the output register; the
// sequencer holds in its put state until that register frees, and no new
// knot is taken meanwhile. Nothing is lost or repeated.
module monotone_spline_slope_limiter #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	msl_in_if.sink           knot_in,
	msl_out_if.source        res_out
);

	localparam int W = VALUE_WIDTH;
	localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
	// Largest delta whose triple still fits.
	localparam logic [W-1:0] DELTA_MAX = SIGN_BIT / W'(3);

	msl_pkg::msl_state_t state_q;

	// Knot awaiting its right neighbour, and its left secant.
	logic signed [W-1:0] held_x_q, held_y_q, held_slope_q;
	logic                held_valid_q;
	logic [W-1:0]        left_sec_q;
	logic                left_valid_q, left_err_q;

	// Knot just taken.
	logic signed [W-1:0] cur_x_q, cur_y_q, cur_slope_q;
	logic                cur_last_q;
	logic                seg_err_q;

	// Output register.
	logic                out_valid_q;
	logic signed [W-1:0] slope_q;
	logic                clamp_q, err_q, last_q;

	logic accept;
	assign knot_in.ready = (state_q == msl_pkg::ST_IDLE);
	assign accept        = knot_in.valid && knot_in.ready;

	// Segment between held knot and the incoming one.
	logic signed [W:0] dy;
	logic [W:0]        dy_abs;
	logic [W-1:0]      dx;
	logic              seg_err;
	assign dy      = {knot_in.knot_y[W-1], knot_in.knot_y} - {held_y_q[W-1], held_y_q};
	assign dy_abs  = dy[W] ? -dy : dy;
	assign dx      = knot_in.knot_x - held_x_q;
	assign seg_err = knot_in.knot_x <= held_x_q;

	logic                div_start;
	logic [W-1:0]        div_quot;
	msl_pkg::div_stat_t  div_stat;
	assign div_start = accept && held_valid_q && !seg_err;

	msl_divider #(
		.VALUE_WIDTH  (VALUE_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dy_abs[W-1:0]),
		.divisor (dx),
		.quot    (div_quot),
		.stat    (div_stat)
	);

	// Right secant of the held knot; zero on an order fault.
	logic [W-1:0] right_sec;
	assign right_sec = seg_err_q ? '0 : div_quot;

	// Shared limiter: one result per put state.
	logic                put1, put2, out_free, load;
	logic signed [W-1:0] e_slope;
	logic                e_rv, e_err;
	logic [W-1:0]        e_rs, delta, tri3, smag;
	logic                neg, apply, clamp;
	logic signed [W-1:0] e_out;

	assign put1     = (state_q == msl_pkg::ST_PUT1);
	assign put2     = (state_q == msl_pkg::ST_PUT2);
	assign out_free = !out_valid_q || res_out.ready;
	assign load     = (put1 || put2) && out_free;

	always_comb begin
		e_slope = put1 ? held_slope_q : cur_slope_q;
		e_rv    = put1;
		e_rs    = put1 ? right_sec : '0;
		e_err   = left_err_q || (put1 && seg_err_q);
		if (left_valid_q && e_rv) begin
			delta = (left_sec_q < e_rs) ? left_sec_q : e_rs;
		end else begin
			delta = left_valid_q ? left_sec_q : e_rs;
		end
		tri3  = delta + (delta << 1);
		neg   = e_slope[W-1];
		smag  = neg ? -e_slope : e_slope;
		apply = !e_err && (left_valid_q || e_rv) && (delta <= DELTA_MAX);
		clamp = apply && (smag > tri3);
		if (clamp) begin
			e_out = neg ? -tri3 : tri3;
		end else begin
			e_out = e_slope;
		end
	end

	// Sequencer and held-knot state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= msl_pkg::ST_IDLE;
			held_valid_q <= 1'b0;
			left_valid_q <= 1'b0;
			left_err_q   <= 1'b0;
			left_sec_q   <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			held_slope_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !res_out.ready);
			case (state_q)
				msl_pkg::ST_IDLE: begin
					if (accept) begin
						if (held_valid_q) begin
							state_q <= seg_err ? msl_pkg::ST_PUT1 : msl_pkg::ST_DIV;
						end else begin
							// New spline: no left neighbour.
							left_valid_q <= 1'b0;
							left_sec_q   <= '0;
							left_err_q   <= 1'b0;
							if (knot_in.last_knot) begin
								state_q <= msl_pkg::ST_PUT2;
							end else begin
								held_x_q     <= knot_in.knot_x;
								held_y_q     <= knot_in.knot_y;
								held_slope_q <= knot_in.knot_slope;
								held_valid_q <= 1'b1;
							end
						end
					end
				end
				msl_pkg::ST_DIV: begin
					if (div_stat.done) begin
						state_q <= msl_pkg::ST_PUT1;
					end
				end
				msl_pkg::ST_PUT1: begin
					if (out_free) begin
						left_valid_q <= 1'b1;
						left_sec_q   <= right_sec;
						left_err_q   <= seg_err_q;
						if (cur_last_q) begin
							state_q <= msl_pkg::ST_PUT2;
						end else begin
							held_x_q     <= cur_x_q;
							held_y_q     <= cur_y_q;
							held_slope_q <= cur_slope_q;
							state_q      <= msl_pkg::ST_IDLE;
						end
					end
				end
				msl_pkg::ST_PUT2: begin
					if (out_free) begin
						// Flush: spline done.
						held_valid_q <= 1'b0;
						held_x_q     <= '0;
						held_y_q     <= '0;
						held_slope_q <= '0;
						left_valid_q <= 1'b0;
						left_sec_q   <= '0;
						left_err_q   <= 1'b0;
						state_q      <= msl_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= msl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q     <= knot_in.knot_x;
			cur_y_q     <= knot_in.knot_y;
			cur_slope_q <= knot_in.knot_slope;
			cur_last_q  <= knot_in.last_knot;
			seg_err_q   <= seg_err;
		end
		if (load) begin
			slope_q <= e_out;
			clamp_q <= clamp;
			err_q   <= e_err;
			last_q  <= put2;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.slope_out   = slope_q;
	assign res_out.was_clamped = clamp_q;
	assign res_out.order_error = err_q;
	assign res_out.last_out    = last_q;

endmodule

// ===== hw/rtl/msl_checker.sv =====
// Checker: port-level assertions for the slope limiter, bound to the top level.
module msl_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   in_last,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] out_slope,
	input logic                   out_clamped,
	input logic                   out_err
);

	// Result request holds while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_slope))
		else $error("result slope changed while stalled");

	// A last knot always leaves results to flush, so the block is busy next.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("knot taken right after a last knot");

	// Faulted segments pass slopes unchanged.
	a_clamp_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_clamped && out_err))
		else $error("clamp reported on an order fault");

endmodule

bind monotone_spline_slope_limiter msl_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_msl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (knot_in.valid),
	.in_ready   (knot_in.ready),
	.in_last    (knot_in.last_knot),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.out_slope  (res_out.slope_out),
	.out_clamped(res_out.was_clamped),
	.out_err    (res_out.order_error)
);

// ===== tb/tb_monotone_spline_slope_limiter.sv =====
`timescale 1ns / 1ps
// Testbench for the monotone spline slope limiter: directed and random knot streams checked against a slope predictor.
module tb_monotone_spline_slope_limiter;

	localparam int VW = 32;
	localparam int FB = 16;
	// Secant magnitudes saturate at 2^(VW-1); a delta above a third of that can never clamp.
	localparam longint SAT_SECANT = longint'(1) <<< (VW - 1);
	localparam longint MAX_DELTA = SAT_SECANT / 3;
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	// The limit covers every stall at its worst several times over.
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_AT = 120;       // knots taken before the long receiver hold-off
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 80;    // a bit over one knot's worth of sequencing

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] slope;
		logic                 last;
	} knot_t;

	typedef struct packed {
		logic signed [VW-1:0] slope;
		logic                 clamped;
		logic                 order_err;
		logic                 last;
	} limited_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	msl_in_if #(.VALUE_WIDTH(VW)) knot_in ();
	msl_out_if #(.VALUE_WIDTH(VW)) res_out ();

	monotone_spline_slope_limiter #(
		.VALUE_WIDTH  (VW),
		.FRACTION_BITS(FB)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.knot_in(knot_in),
		.res_out(res_out)
	);

	knot_t    knot_queue[$];        // knots waiting to be offered
	limited_t expected_slopes[$];   // limited slopes owed by the block, oldest first

	int   idle_pct = 0;             // chance in percent that either side starts an idle burst
	int   knots_queued = 0;
	int   knots_taken = 0;
	int   mismatches = 0;
	int   cycles = 0;
	int   send_gap = 0;
	int   sink_gap = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	logic knot_fire = 1'b0;         // knot request accepted at the last rising edge

	// Predictor state: the knot still waiting for its right neighbour and its left segment.
	knot_t      held_knot;
	logic       held_valid = 1'b0;
	logic       left_valid = 1'b0;
	logic       left_order_error = 1'b0;
	logic [VW:0] left_secant = '0;

	// |dy| * 2^FB / dx, truncated, saturated; dx > 0 is the caller's business.
	function automatic longint secant_mag(input logic signed [VW-1:0] x0, y0, x1, y1);
		longint dx;
		longint dy;
		longint q;
		dx = longint'(x1) - longint'(x0);
		dy = longint'(y1) - longint'(y0);
		if (dy < 0)
			dy = -dy;
		q = (dy <<< FB) / dx;
		return (q > SAT_SECANT) ? SAT_SECANT : q;
	endfunction

	// Hyman rule: clamp |slope| to 3*delta, delta being the smaller neighbour secant.
	// A missing neighbour does not bound; an order fault passes the slope untouched.
	function automatic limited_t limit_slope(input logic signed [VW-1:0] slope,
			input logic lv, input longint ls, input logic rv, input longint rs,
			input logic err, input logic last);
		limited_t res;
		longint   mag;
		longint   delta;
		longint   bound;
		res.slope = slope;
		res.clamped = 1'b0;
		res.order_err = err;
		res.last = last;
		mag = longint'(slope);
		if (mag < 0)
			mag = -mag;
		if (!err && (lv || rv)) begin
			if (lv && rv)
				delta = (ls < rs) ? ls : rs;
			else
				delta = lv ? ls : rs;
			if (delta <= MAX_DELTA) begin
				bound = 3 * delta;
				if (mag > bound) begin
					res.clamped = 1'b1;
					// sign is kept, negative slopes included
					res.slope = slope[VW-1] ? VW'(-bound) : VW'(bound);
				end
			end
		end
		return res;
	endfunction

	// One accepted knot: releases the held knot's result, and on a last knot its own too.
	function automatic void apply_knot(input knot_t k);
		logic   err;
		longint rs;
		if (held_valid) begin
			err = ($signed(k.x) <= $signed(held_knot.x));
			rs = err ? 64'sd0 : secant_mag(held_knot.x, held_knot.y, k.x, k.y);
			expected_slopes.insert(expected_slopes.size(), limit_slope(held_knot.slope,
				left_valid, longint'(left_secant), 1'b1, rs, left_order_error | err, 1'b0));
			left_valid = 1'b1;
			left_secant = rs[VW:0];
			left_order_error = err;
		end else begin
			left_valid = 1'b0;
			left_secant = '0;
			left_order_error = 1'b0;
		end
		if (k.last) begin
			expected_slopes.insert(expected_slopes.size(), limit_slope(k.slope, left_valid,
				longint'(left_secant), 1'b0, 64'sd0, left_order_error, 1'b1));
			// flush: the next knot opens a new spline
			held_valid = 1'b0;
			left_valid = 1'b0;
			left_secant = '0;
			left_order_error = 1'b0;
		end else begin
			held_knot = k;
			held_valid = 1'b1;
		end
	endfunction

	task automatic push_knot(input logic signed [VW-1:0] x, y, s, input logic last);
		knot_t k;
		k.x = x;
		k.y = y;
		k.slope = s;
		k.last = last;
		knot_queue.insert(knot_queue.size(), k);
		knots_queued++;
	endtask

	task automatic queue_directed();
		// lone knots: no neighbours, slope passes unchanged
		push_knot(0, 0, VMAX, 1'b1);
		push_knot(VMIN, VMAX, VMIN, 1'b1);
		// full-range segment: secant exactly 1.0, both slopes clamp to +-3.0
		push_knot(VMIN, VMIN, VMIN, 1'b0);
		push_knot(VMAX, VMAX, VMAX, 1'b1);
		// repeated x: both knots of the segment flagged
		push_knot(100, 5, VMAX, 1'b0);
		push_knot(100, -5, VMIN, 1'b1);
		// x steps back mid-spline; flag spreads to both ends of the bad segment
		push_knot(-1000, 0, 32'sd4000000, 1'b0);
		push_knot(500, 7, -32'sd9000000, 1'b0);
		push_knot(400, 9, 32'sd1, 1'b0);
		push_knot(900, 9, 32'sd123456, 1'b1);
		// dx of one LSB over the full y range: secant saturates, nothing clamps
		push_knot(0, VMIN, VMIN, 1'b0);
		push_knot(1, VMAX, VMAX, 1'b1);
		// flat: delta zero, any nonzero slope goes to zero
		push_knot(0, 42, -1, 1'b0);
		push_knot(65536, 42, 0, 1'b0);
		push_knot(131072, 42, 1, 1'b1);
		// slope on the bound stays, one past it clamps
		push_knot(0, 0, 196608, 1'b0);
		push_knot(65536, 65536, -196609, 1'b1);
		// largest delta that still limits, then the first one that cannot
		push_knot(0, 0, VMAX, 1'b0);
		push_knot(65536, 715827882, VMIN, 1'b0);
		push_knot(131072, 1431655765, VMAX, 1'b1);
		// unequal neighbour secants: the smaller sets the bound
		push_knot(0, 0, 32'sd100000, 1'b0);
		push_knot(65536, 65536, 32'sd500000, 1'b0);
		push_knot(98304, 196608, -32'sd700000, 1'b0);
		push_knot(163840, 200000, 32'sd0, 1'b1);
	endtask

	// One spline of 1..8 knots. Mostly well ordered; two in ten have shuffled or repeated x.
	task automatic queue_random_spline();
		logic signed [VW-1:0] xs[8];
		logic signed [VW-1:0] ys[8];
		logic signed [VW-1:0] s;
		longint offs[8];
		longint span;
		longint x0;
		longint sec;
		int     n;
		int     pick;
		int     dup;
		n = ($urandom_range(7) == 0) ? 1 : $urandom_range(8, 2);
		span = 0;
		offs[0] = 0;
		for (int i = 1; i < n; i++) begin
			span += (longint'($urandom) & ((longint'(1) <<< $urandom_range(28, 0)) - 1)) + 1;
			offs[i] = span;
		end
		x0 = -SAT_SECANT + longint'($urandom_range(32'(64'hFFFF_FFFF - span), 0));
		for (int i = 0; i < n; i++)
			xs[i] = VW'(x0 + offs[i]);
		if ($urandom_range(1)) begin
			for (int i = 0; i < n; i++)
				ys[i] = $urandom;
		end else begin
			ys[0] = $urandom;
			for (int i = 1; i < n; i++)
				ys[i] = ys[i-1] + ($signed($urandom) >>> $urandom_range(31, 0));
		end
		pick = $urandom_range(9);
		if (n > 1 && pick == 0) begin
			for (int i = 0; i < n; i++)
				xs[i] = $urandom;
		end else if (n > 1 && pick == 1) begin
			dup = $urandom_range(n - 1, 1);
			xs[dup] = xs[dup-1];
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					case ($urandom_range(4))
						0: s = VMIN;
						1: s = VMAX;
						2: s = 0;
						3: s = 1;
						default: s = -1;
					endcase
				end
				1, 2: begin
					// land on or next to the left-secant bound
					s = $urandom;
					if (i > 0 && $signed(xs[i]) > $signed(xs[i-1])) begin
						sec = secant_mag(xs[i-1], ys[i-1], xs[i], ys[i]);
						if (sec <= MAX_DELTA) begin
							s = VW'(3 * sec + longint'($urandom_range(2)) - 1);
							if ($urandom_range(1))
								s = -s;
						end
					end
				end
				3, 4, 5: s = $signed($urandom) >>> $urandom_range(31, 0);
				default: s = $urandom;
			endcase
			push_knot(xs[i], ys[i], s, i == n - 1);
		end
	endtask

	task automatic wait_sent();
		while (knot_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		wait_sent();
		while (knot_in.valid || expected_slopes.size() != 0)
			@(posedge clk);
	endtask

	// Sender: a request stays up until taken; between requests, random idle bursts.
	always @(negedge clk) begin : knot_driver
		knot_t k;
		if (arst_n && !(knot_in.valid && !knot_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				knot_in.valid <= 1'b0;
			end else if (knot_queue.size() == 0) begin
				knot_in.valid <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				send_gap = $urandom_range(15, 0);
				knot_in.valid <= 1'b0;
			end else begin
				k = knot_queue.pop_front();
				knot_in.knot_x <= k.x;
				knot_in.knot_y <= k.y;
				knot_in.knot_slope <= k.slope;
				knot_in.last_knot <= k.last;
				knot_in.valid <= 1'b1;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once traffic is going so that
	// the output register fills and the block stops taking knots.
	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				res_out.ready <= 1'b0;
			end else if (!hold_done && knots_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_out.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				res_out.ready <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				sink_gap = $urandom_range(15, 0);
				res_out.ready <= 1'b0;
			end else begin
				res_out.ready <= 1'b1;
			end
		end
	end

	// Sample both channels at the rising edge: predict from taken knots, then check results.
	always @(posedge clk or negedge arst_n) begin : result_check
		knot_t    got;
		limited_t want;
		if (!arst_n) begin
			knot_fire <= 1'b0;
		end else begin
			knot_fire <= knot_in.valid && knot_in.ready;
			if (knot_in.valid && knot_in.ready) begin
				got.x = knot_in.knot_x;
				got.y = knot_in.knot_y;
				got.slope = knot_in.knot_slope;
				got.last = knot_in.last_knot;
				apply_knot(got);
				knots_taken++;
			end
			if (res_out.valid && res_out.ready) begin
				if (expected_slopes.size() == 0) begin
					$error("unexpected result: slope_out %0d", $signed(res_out.slope_out));
					mismatches++;
				end else begin
					want = expected_slopes.pop_front();
					if (res_out.slope_out !== want.slope) begin
						$error("slope_out: expected %0d, got %0d",
							$signed(want.slope), $signed(res_out.slope_out));
						mismatches++;
					end
					if (res_out.was_clamped !== want.clamped) begin
						$error("was_clamped: expected %0b, got %0b",
							want.clamped, res_out.was_clamped);
						mismatches++;
					end
					if (res_out.order_error !== want.order_err) begin
						$error("order_error: expected %0b, got %0b",
							want.order_err, res_out.order_error);
						mismatches++;
					end
					if (res_out.last_out !== want.last) begin
						$error("last_out: expected %0b, got %0b", want.last, res_out.last_out);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$error("timeout with %0d results outstanding", expected_slopes.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		knot_in.valid = 1'b0;
		knot_in.knot_x = '0;
		knot_in.knot_y = '0;
		knot_in.knot_slope = '0;
		knot_in.last_knot = 1'b0;
		res_out.ready = 1'b0;
		idle_pct = 20;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_directed();
		wait_drained();

		// moderate idling; the long receiver hold-off lands in here
		idle_pct = 25;
		while (knots_queued < 700)
			queue_random_spline();
		// sender pauses until every owed result is out
		wait_drained();

		idle_pct = 50;
		while (knots_queued < 1250)
			queue_random_spline();
		wait_sent();

		idle_pct = 8;
		while (knots_queued < 1500)
			queue_random_spline();
		wait_sent();

		// last stretch at full rate on both sides
		idle_pct = 0;
		while (knots_queued < 1850)
			queue_random_spline();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_slopes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/msl_pkg.sv
hw/rtl/msl_if.sv
hw/rtl/msl_divider.sv
hw/rtl/monotone_spline_slope_limiter.sv
hw/rtl/msl_checker.sv
tb/tb_monotone_spline_slope_limiter.sv
